/* src/idm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idm_pkg
// Shared types and constants for the vector impedance datapath.
// ---------------------------------------------------------------------------
package idm_pkg;

  localparam int XW = 30;
  localparam int ZW = 34;
  localparam int CORDIC_STEPS = 20;

  localparam logic [2:0] CFG_FULL_SCALE = 3'd0;
  localparam logic [2:0] CFG_OPEN_VOLTS = 3'd1;
  localparam logic [2:0] CFG_SERIES_RES = 3'd2;
  localparam logic [2:0] CFG_GAIN       = 3'd3;
  localparam logic [2:0] CFG_FREQ       = 3'd4;

  localparam logic [29:0] CORDIC_K = 30'd652032874;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  typedef struct packed {
    logic [31:0] res;
    logic        kind;
    logic        zi_zero;
    logic        om_zero;
    logic        den_zero;
  } rsb_t;

  typedef struct packed {
    logic [31:0] res;
    logic        kind;
    logic [31:0] react;
    logic        degen;
  } res_t;

  function automatic logic [31:0] cordic_atan(input int idx);
    logic [31:0] a;
    case (idx)
      0: a = 32'd536870912;
      1: a = 32'd316933406;
      2: a = 32'd167458907;
      3: a = 32'd85004756;
      4: a = 32'd42667331;
      5: a = 32'd21354465;
      6: a = 32'd10679838;
      7: a = 32'd5340245;
      8: a = 32'd2670163;
      9: a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

/* src/idm_cordic_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idm_cordic_cell
// One registered CORDIC rotation step with a fixed shift.
// ---------------------------------------------------------------------------
module idm_cordic_cell import idm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 vld_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(cordic_atan(IDX));

  logic                 vld_r;
  logic signed [XW-1:0] x_r, y_r, xs, ys;
  logic signed [ZW-1:0] z_r;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[ZW-1]) begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - ATAN;
      end else begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + ATAN;
      end
    end
  end

  assign vld_o = vld_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

/* src/idm_div_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idm_div_cell
// One restoring division step: yields one quotient bit per cell.
// ---------------------------------------------------------------------------
module idm_div_cell #(
  parameter int DW = 47,
  parameter int QB = 53,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW-1:0] r_i,
  input  logic [DW-1:0] d_i,
  input  logic [QB-1:0] nlo_i,
  input  logic [QB-1:0] q_i,
  input  logic [SW-1:0] sb_i,
  output logic          vld_o,
  output logic [DW-1:0] r_o,
  output logic [DW-1:0] d_o,
  output logic [QB-1:0] nlo_o,
  output logic [QB-1:0] q_o,
  output logic [SW-1:0] sb_o
);

  logic          vld_r;
  logic [DW-1:0] r_r, d_r;
  logic [QB-1:0] nlo_r, q_r;
  logic [SW-1:0] sb_r;
  logic [DW:0]   rs, diff;
  logic          ge;

  assign rs   = {r_i, nlo_i[QB-1]};
  assign ge   = rs >= {1'b0, d_i};
  assign diff = rs - {1'b0, d_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= ge ? diff[DW-1:0] : rs[DW-1:0];
      d_r   <= d_i;
      nlo_r <= {nlo_i[QB-2:0], 1'b0};
      q_r   <= {q_i[QB-2:0], ge};
      sb_r  <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign r_o = r_r;
  assign d_o = d_r;
  assign nlo_o = nlo_r;
  assign q_o = q_r;
  assign sb_o = sb_r;

endmodule

/* src/idm_div_chain.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idm_div_chain
// Pipelined divider: QB division cells, overflow flagged when the quotient
// does not fit in QB bits.
// ---------------------------------------------------------------------------
module idm_div_chain #(
  parameter int NW = 85,
  parameter int DW = 47,
  parameter int QB = 53,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] sb_i,
  output logic          vld_o,
  output logic [QB-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] sb_o
);

  logic          vld_a [QB+1];
  logic [DW-1:0] r_a   [QB+1];
  logic [DW-1:0] d_a   [QB+1];
  logic [QB-1:0] nlo_a [QB+1];
  logic [QB-1:0] q_a   [QB+1];
  logic [SW:0]   sb_a  [QB+1];
  logic [DW-1:0] top;

  assign top      = DW'(num[NW-1:QB]);
  assign vld_a[0] = vld_i;
  assign r_a[0]   = top;
  assign d_a[0]   = den;
  assign nlo_a[0] = num[QB-1:0];
  assign q_a[0]   = '0;
  assign sb_a[0]  = {top >= den, sb_i};

  for (genvar g = 0; g < QB; g++) begin : g_cell
    idm_div_cell #(.DW(DW), .QB(QB), .SW(SW + 1)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_a[g]),
      .r_i   (r_a[g]),
      .d_i   (d_a[g]),
      .nlo_i (nlo_a[g]),
      .q_i   (q_a[g]),
      .sb_i  (sb_a[g]),
      .vld_o (vld_a[g+1]),
      .r_o   (r_a[g+1]),
      .d_o   (d_a[g+1]),
      .nlo_o (nlo_a[g+1]),
      .q_o   (q_a[g+1]),
      .sb_o  (sb_a[g+1])
    );
  end

  assign vld_o = vld_a[QB];
  assign quo   = q_a[QB];
  assign ovf   = sb_a[QB][SW];
  assign sb_o  = sb_a[QB][SW-1:0];

endmodule

/* src/vector_impedance_from_divider_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_impedance_from_divider_core
// Impedance from a divider measurement: CORDIC rotation, complex division,
// inductance / capacitance conversion with capacitance correction.
// ---------------------------------------------------------------------------
// Throughput: one request per cycle while the output skid stage is empty; set by the CORDIC and divider cell rows.
// Stalls freeze the whole pipeline only once the output skid stage is full.
// Reset (synchronous, rst_n low) clears all valids and loads register defaults.
module vector_impedance_from_divider_core import idm_pkg::*; #(
  parameter int SAMPLE_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_adc_sample,
  input  logic [12:0]        in_xor_count,
  input  logic               in_phase_negative,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_resistance_milliohms,
  output logic               out_reactance_kind,
  output logic [31:0]        out_reactive_thousandths,
  output logic               out_degenerate,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  localparam logic [23:0] Q_C = 24'((64'd1 << 31) / 64'(SAMPLE_COUNT));
  localparam logic [15:0] R_C = 16'((64'd1 << 31) % 64'(SAMPLE_COUNT));
  localparam logic [37:0] M_C = 38'((64'd1 << 45) / 64'(SAMPLE_COUNT) + 64'd1);
  localparam logic [52:0] Z_CAP = 53'(64'd1 << 52);
  localparam logic [58:0] C_CAP = 59'(64'd1 << 58);
  localparam logic [58:0] U32_CAP = 59'(64'd4294967295);
  localparam logic [96:0] C_NUM = {44'd10000000000000, 53'd0};
  localparam logic [25:0] M85 = 26'((64'd1 << 45) / 64'd1000000 + 64'd1);
  localparam logic [22:0] M4 = 23'((64'd1 << 36) / 64'd10000 + 64'd1);
  localparam logic [45:0] M3 = 46'((64'd1 << 57) / 64'd3125 + 64'd1);
  localparam logic [58:0] T_SAT = 59'((64'd4294967295 * 64'd100000 + 64'd22) / 64'd23);

  logic en;

  // configuration
  logic [17:0] fs_r, voc_r, gain_r;
  logic [19:0] rs_r;
  logic [23:0] freq_r;
  logic [37:0] rg_r;
  logic [55:0] omega_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r   <= 18'd108134;
      voc_r  <= 18'd90112;
      rs_r   <= 20'd5100;
      gain_r <= 18'd52429;
      freq_r <= 24'd372531;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_SCALE: fs_r   <= cfg_wdata[17:0];
        CFG_OPEN_VOLTS: voc_r  <= cfg_wdata[17:0];
        CFG_SERIES_RES: rs_r   <= cfg_wdata[19:0];
        CFG_GAIN:       gain_r <= cfg_wdata[17:0];
        CFG_FREQ:       freq_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rg_r    <= 38'(rs_r) * 38'(gain_r);
    omega_r <= 56'(TWO_PI_Q29) * 56'(freq_r);
  end

  // front stages: volts and angle
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [33:0] p1_r;
  logic [28:0] a1_r;
  logic [36:0] b1_r, b2_r;
  logic        n1_r, n2_r;
  logic [18:0] volts2_r;
  logic [66:0] am2_r;
  logic [31:0] ang3_r;
  logic [47:0] xm3_r;
  logic signed [XW-1:0] x4_r;
  logic signed [ZW-1:0] z4_r;

  logic [31:0] p4;
  logic [17:0] t;
  logic [18:0] rr, vq;
  logic [4:0]  t2;
  logic [14:0] r2;
  logic [31:0] ang, aw, angp;
  logic signed [XW-1:0] x0;

  assign p4 = p1_r[33:2];
  assign t  = p4[31:14];
  assign rr = 19'(p4[13:0]) + 19'(t);
  assign t2 = rr[18:14];
  assign r2 = 15'(rr[13:0]) + 15'(t2);
  assign vq = 19'(t) + 19'(t2) + 19'(r2 >= 15'd16383);

  always_comb begin
    ang = b2_r[31:0] + 32'(am2_r[66:45]);
    if (n2_r) begin
      ang = 32'd0 - ang;
    end
  end

  assign x0   = signed'(XW'(xm3_r[47:22]));
  assign aw   = ang3_r + 32'h4000_0000;
  assign angp = aw[31] ? ang3_r + 32'h8000_0000 : ang3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= 34'(in_adc_sample) * 34'(fs_r);
      a1_r     <= 29'(in_xor_count) * 29'(R_C);
      b1_r     <= 37'(in_xor_count) * 37'(Q_C);
      n1_r     <= in_phase_negative;
      volts2_r <= vq;
      am2_r    <= 67'(a1_r) * 67'(M_C);
      b2_r     <= b1_r;
      n2_r     <= n1_r;
      ang3_r   <= ang;
      xm3_r    <= 48'(volts2_r) * 48'(CORDIC_K);
      x4_r     <= aw[31] ? -x0 : x0;
      z4_r     <= ZW'(signed'(angp));
    end
  end

  // CORDIC row
  logic                 cv [CORDIC_STEPS+1];
  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];

  assign cv[0] = v4_r;
  assign cx[0] = x4_r;
  assign cy[0] = '0;
  assign cz[0] = z4_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    idm_cordic_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (cv[g]),
      .x_i   (cx[g]),
      .y_i   (cy[g]),
      .z_i   (cz[g]),
      .vld_o (cv[g+1]),
      .x_o   (cx[g+1]),
      .y_o   (cy[g+1]),
      .z_o   (cz[g+1])
    );
  end

  // complex products
  logic signed [21:0] vr, vi;
  logic signed [22:0] dr1_r, di1_r, vr1_r, vi1_r;
  logic signed [45:0] m_r [6];
  logic signed [46:0] nr, ni;
  logic        vp1_r, vp2_r, vp3_r, vp4_r, vp5_r;
  logic        neg3_r [2];
  logic [46:0] abs3_r [2];
  logic [46:0] den3_r, den4_r, den5_r;
  logic        dz3_r, dz4_r, dz5_r;
  logic        neg4_r [2];
  logic        neg5_r [2];
  logic [42:0] ll4_r [2];
  logic [42:0] lh4_r [2];
  logic [41:0] hl4_r [2];
  logic [41:0] hh4_r [2];
  logic [84:0] num5_r [2];

  assign vr = cx[CORDIC_STEPS][XW-1:8];
  assign vi = cy[CORDIC_STEPS][XW-1:8];
  assign nr = 47'(m_r[0]) + 47'(m_r[1]);
  assign ni = 47'(m_r[2]) - 47'(m_r[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      dr1_r  <= signed'({5'd0, voc_r}) - 23'(vr);
      di1_r  <= -23'(vi);
      vr1_r  <= 23'(vr);
      vi1_r  <= 23'(vi);
      m_r[0] <= 46'(vr1_r) * 46'(dr1_r);
      m_r[1] <= 46'(vi1_r) * 46'(di1_r);
      m_r[2] <= 46'(vi1_r) * 46'(dr1_r);
      m_r[3] <= 46'(vr1_r) * 46'(di1_r);
      m_r[4] <= 46'(dr1_r) * 46'(dr1_r);
      m_r[5] <= 46'(di1_r) * 46'(di1_r);
      neg3_r[0] <= nr[46];
      neg3_r[1] <= ni[46];
      abs3_r[0] <= nr[46] ? unsigned'(-nr) : unsigned'(nr);
      abs3_r[1] <= ni[46] ? unsigned'(-ni) : unsigned'(ni);
      den3_r <= unsigned'(47'(m_r[4]) + 47'(m_r[5]));
      dz3_r  <= (47'(m_r[4]) + 47'(m_r[5])) == '0;
      den4_r <= den3_r;
      dz4_r  <= dz3_r;
      den5_r <= den4_r;
      dz5_r  <= dz4_r;
      for (int k = 0; k < 2; k++) begin
        neg4_r[k] <= neg3_r[k];
        neg5_r[k] <= neg4_r[k];
        ll4_r[k]  <= 43'(abs3_r[k][23:0]) * 43'(rg_r[18:0]);
        lh4_r[k]  <= 43'(abs3_r[k][23:0]) * 43'(rg_r[37:19]);
        hl4_r[k]  <= 42'(abs3_r[k][46:24]) * 42'(rg_r[18:0]);
        hh4_r[k]  <= 42'(abs3_r[k][46:24]) * 42'(rg_r[37:19]);
        num5_r[k] <= 85'(ll4_r[k]) + (85'(lh4_r[k]) << 19)
                   + (85'(hl4_r[k]) << 24) + (85'(hh4_r[k]) << 43);
      end
    end
  end

  // impedance division
  logic        vdr, vdi, ovf_r, ovf_i, nrn_d, dz_d, nin_d;
  logic [52:0] qr, qi;

  idm_div_chain #(.NW(85), .DW(47), .QB(53), .SW(2)) u_div_re (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vp5_r),
    .num   (num5_r[0]),
    .den   (den5_r),
    .sb_i  ({neg5_r[0], dz5_r}),
    .vld_o (vdr),
    .quo   (qr),
    .ovf   (ovf_r),
    .sb_o  ({nrn_d, dz_d})
  );

  idm_div_chain #(.NW(85), .DW(47), .QB(53), .SW(1)) u_div_im (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vp5_r),
    .num   (num5_r[1]),
    .den   (den5_r),
    .sb_i  (neg5_r[1]),
    .vld_o (vdi),
    .quo   (qi),
    .ovf   (ovf_i),
    .sb_o  (nin_d)
  );

  // resistance, reactive division setup
  logic        vq1_r, vq2_r, vq3_r;
  logic [52:0] zra1_r, zia1_r;
  logic        nrn1_r, nin1_r, dz1_r;
  logic [62:0] mprod;
  logic [46:0] mres, mneg;
  logic [31:0] res;
  rsb_t        sb2_r, sb3_r;
  logic [53:0] zll2_r, zlh2_r;
  logic [54:0] zhl2_r, zhh2_r;
  logic [46:0] lh2_r;
  logic [45:0] ll2_r;
  logic [108:0] dmul3_r;
  logic [72:0]  lmul3_r;

  assign mprod = 63'(zra1_r) * 63'(10'd1000);
  assign mres  = mprod[62:16];
  assign mneg  = (mres > 47'h8000_0000) ? 47'h8000_0000 : mres;

  always_comb begin
    if (!nrn1_r) begin
      res = (mres > 47'h7FFF_FFFF) ? 32'h7FFF_FFFF : mres[31:0];
    end else begin
      res = 32'd0 - mneg[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zra1_r <= (ovf_r || qr > Z_CAP) ? Z_CAP : qr;
      zia1_r <= (ovf_i || qi > Z_CAP) ? Z_CAP : qi;
      nrn1_r <= nrn_d;
      nin1_r <= nin_d;
      dz1_r  <= dz_d;
      sb2_r  <= '{res: res, kind: !(!nin1_r && zia1_r != '0), zi_zero: zia1_r == '0,
                  om_zero: omega_r == '0, den_zero: dz1_r};
      zll2_r <= 54'(zia1_r[25:0]) * 54'(omega_r[27:0]);
      zlh2_r <= 54'(zia1_r[25:0]) * 54'(omega_r[55:28]);
      zhl2_r <= 55'(zia1_r[52:26]) * 55'(omega_r[27:0]);
      zhh2_r <= 55'(zia1_r[52:26]) * 55'(omega_r[55:28]);
      lh2_r  <= 47'(zia1_r[52:26]) * 47'(20'd1000000);
      ll2_r  <= 46'(zia1_r[25:0]) * 46'(20'd1000000);
      dmul3_r <= 109'(zll2_r) + (109'(zlh2_r) << 28) + (109'(zhl2_r) << 26)
               + (109'(zhh2_r) << 54);
      lmul3_r <= (73'(lh2_r) << 26) + 73'(ll2_r);
      sb3_r   <= sb2_r;
    end
  end

  logic [96:0]  xnum;
  logic [108:0] xden;

  assign xnum = sb3_r.kind ? C_NUM : {3'd0, lmul3_r, 21'd0};
  assign xden = sb3_r.kind ? dmul3_r : 109'(omega_r);

  logic        vdx, ovf_x;
  logic [58:0] qx;
  logic [$bits(rsb_t)-1:0] sbx;

  idm_div_chain #(.NW(97), .DW(109), .QB(59), .SW($bits(rsb_t))) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vq3_r),
    .num   (xnum),
    .den   (xden),
    .sb_i  (sb3_r),
    .vld_o (vdx),
    .quo   (qx),
    .ovf   (ovf_x),
    .sb_o  (sbx)
  );

  // capacitance correction
  logic        vr1_v_r, vr2_v_r;
  rsb_t        rsb1_r, rsb2_r;
  logic [31:0] lval1_r, lval2_r;
  logic [58:0] cq;
  logic [49:0] y23;
  logic [24:0] x85_r;
  logic [21:0] mid_r;
  logic [44:0] y_r;
  logic        lt1k1_r, lt200k1_r, gt3m1_r, big1_r;
  logic        lt1k2_r, lt200k2_r, gt3m2_r, big2_r;
  logic [50:0] p85_r;
  logic [44:0] pmid_r;
  logic [44:0] yll_r, ylh_r;
  logic [45:0] yhl_r, yhh_r;
  logic [90:0] ysum;
  logic [31:0] cval;
  res_t        fin;

  assign cq  = (ovf_x || qx > C_CAP) ? C_CAP : qx;
  assign y23 = 50'(cq[44:0]) * 50'(5'd23);

  always_ff @(posedge clk) begin
    if (en) begin
      rsb1_r    <= rsb_t'(sbx);
      lval1_r   <= (ovf_x || qx > U32_CAP) ? 32'hFFFF_FFFF : qx[31:0];
      x85_r     <= 25'(cq[17:0]) * 25'(7'd85);
      mid_r     <= cq[21:0];
      y_r       <= y23[49:5];
      lt1k1_r   <= cq < 59'd1000;
      lt200k1_r <= cq < 59'd200000;
      gt3m1_r   <= cq > 59'd3000000;
      big1_r    <= cq >= T_SAT;
      rsb2_r    <= rsb1_r;
      lval2_r   <= lval1_r;
      lt1k2_r   <= lt1k1_r;
      lt200k2_r <= lt200k1_r;
      gt3m2_r   <= gt3m1_r;
      big2_r    <= big1_r;
      p85_r     <= 51'(x85_r) * 51'(M85);
      pmid_r    <= 45'(mid_r) * 45'(M4);
      yll_r     <= 45'(y_r[21:0]) * 45'(M3[22:0]);
      ylh_r     <= 45'(y_r[21:0]) * 45'(M3[45:23]);
      yhl_r     <= 46'(y_r[44:22]) * 46'(M3[22:0]);
      yhh_r     <= 46'(y_r[44:22]) * 46'(M3[45:23]);
    end
  end

  assign ysum = 91'(yll_r) + (91'(ylh_r) << 23) + (91'(yhl_r) << 22) + (91'(yhh_r) << 45);

  always_comb begin
    if (lt1k2_r) begin
      cval = 32'd0;
    end else if (lt200k2_r) begin
      cval = 32'(p85_r[50:45]);
    end else if (gt3m2_r) begin
      cval = big2_r ? 32'hFFFF_FFFF : ysum[88:57];
    end else begin
      cval = 32'(pmid_r[44:36]);
    end
    fin.res   = rsb2_r.res;
    fin.kind  = rsb2_r.kind;
    fin.react = cval;
    fin.degen = 1'b0;
    if (rsb2_r.den_zero) begin
      fin.res   = 32'h7FFF_FFFF;
      fin.kind  = 1'b0;
      fin.react = 32'hFFFF_FFFF;
      fin.degen = 1'b1;
    end else if (!rsb2_r.kind) begin
      fin.react = rsb2_r.om_zero ? 32'hFFFF_FFFF : lval2_r;
      fin.degen = rsb2_r.om_zero;
    end else if (rsb2_r.zi_zero || rsb2_r.om_zero) begin
      fin.react = 32'hFFFF_FFFF;
      fin.degen = 1'b1;
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
      vp3_r <= 1'b0;
      vp4_r <= 1'b0;
      vp5_r <= 1'b0;
      vq1_r <= 1'b0;
      vq2_r <= 1'b0;
      vq3_r <= 1'b0;
      vr1_v_r <= 1'b0;
      vr2_v_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vp1_r <= cv[CORDIC_STEPS];
      vp2_r <= vp1_r;
      vp3_r <= vp2_r;
      vp4_r <= vp3_r;
      vp5_r <= vp4_r;
      vq1_r <= vdr & vdi;
      vq2_r <= vq1_r;
      vq3_r <= vq2_r;
      vr1_v_r <= vdx;
      vr2_v_r <= vr1_v_r;
    end
  end

  // output register with skid stage
  logic out_vld_r, skid_vld_r;
  res_t out_d_r, skid_d_r;

  assign en = !skid_vld_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (en) begin
      if (out_vld_r && !out_ready) begin
        skid_vld_r <= vr2_v_r;
      end else begin
        out_vld_r <= vr2_v_r;
      end
    end else if (out_ready) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_vld_r && !out_ready) begin
        skid_d_r <= fin;
      end else begin
        out_d_r <= fin;
      end
    end else if (out_ready) begin
      out_d_r <= skid_d_r;
    end
  end

  assign out_valid                = out_vld_r;
  assign out_resistance_milliohms = signed'(out_d_r.res);
  assign out_reactance_kind       = out_d_r.kind;
  assign out_reactive_thousandths = out_d_r.react;
  assign out_degenerate           = out_d_r.degen;

endmodule
